// File: rtl/gregorian_date_normalizer_unit_macros.svh
// Shared assertion macros.
`ifndef GREGORIAN_DATE_NORMALIZER_UNIT_MACROS_SVH
`define GREGORIAN_DATE_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GDN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdn assertion failed");

// Next-cycle implication.
`define GDN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdn assertion failed");

`endif

// File: rtl/gdn_pkg.sv
package gdn_pkg;

   localparam int unsigned RawWidth   = 16;
   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 16;
   localparam int unsigned ProdWidth  = 32;
   localparam int unsigned RemWidth   = 9;

   localparam logic [MonthWidth-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [MonthWidth-1:0] MONTH_JAN = 4'd1;
   localparam logic [MonthWidth-1:0] MONTH_FEB = 4'd2;
   localparam logic [MonthWidth-1:0] MONTH_APR = 4'd4;
   localparam logic [MonthWidth-1:0] MONTH_JUN = 4'd6;
   localparam logic [MonthWidth-1:0] MONTH_SEP = 4'd9;
   localparam logic [MonthWidth-1:0] MONTH_NOV = 4'd11;

   localparam logic [DayWidth-1:0] LEN_FEB      = 5'd28;
   localparam logic [DayWidth-1:0] LEN_FEB_LEAP = 5'd29;
   localparam logic [DayWidth-1:0] LEN_SHORT    = 5'd30;
   localparam logic [DayWidth-1:0] LEN_LONG     = 5'd31;

   // floor(x / 12) = (x * 43691) >> 19 for x < 2^17
   localparam logic [15:0] FOLD_RECIP = 16'd43691;
   localparam int unsigned FoldShift  = 19;
   // floor(y / 400) = ((y >> 4) * 1311) >> 15 for y < 2^16
   localparam logic [10:0] YEAR_RECIP = 11'd1311;
   localparam int unsigned YearShift  = 15;

   localparam logic [RemWidth-1:0] LEAP_CYCLE = 9'd400;
   localparam logic [RemWidth-1:0] CENTURY_1  = 9'd100;
   localparam logic [RemWidth-1:0] CENTURY_2  = 9'd200;
   localparam logic [RemWidth-1:0] CENTURY_3  = 9'd300;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD_MUL,
      ST_FOLD_FIX,
      ST_YEAR_MUL,
      ST_YEAR_FIX,
      ST_LOOP,
      ST_DONE
   } gdn_state_type;

   typedef struct packed {
      logic load;
      logic fold_mul;
      logic fold_fix;
      logic year_mul;
      logic year_fix;
      logic step;
      logic out_load;
   } gdn_cmd_type;

   typedef struct packed {
      logic fits;
   } gdn_status_type;

endpackage

// File: rtl/gdn_datapath.sv
module gdn_datapath (
   input  logic                                  clock,
   input  gdn_pkg::gdn_cmd_type                  cmd,
   input  logic signed [gdn_pkg::RawWidth-1:0]   day_in,
   input  logic signed [gdn_pkg::RawWidth-1:0]   month_in,
   input  logic signed [gdn_pkg::RawWidth-1:0]   year_in,
   output gdn_pkg::gdn_status_type               status,
   output logic [gdn_pkg::DayWidth-1:0]          day_out,
   output logic [gdn_pkg::MonthWidth-1:0]        month_out,
   output logic [gdn_pkg::YearWidth-1:0]         year_out
);
   import gdn_pkg::*;

   logic [RawWidth-1:0]   day_ff, day_in_nxt;
   logic [RawWidth-1:0]   month_ff, month_in_nxt;
   logic [YearWidth-1:0]  year_ff, year_in_nxt;
   logic [ProdWidth-1:0]  prod_ff, prod_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [DayWidth-1:0]   day_out_ff;
   logic [MonthWidth-1:0] month_out_ff;
   logic [YearWidth-1:0]  year_out_ff;

   logic [RawWidth-1:0]   day_mag, month_mag, year_mag;
   logic [RawWidth-1:0]   month_m1;
   logic [12:0]           fold_q;
   logic [RawWidth-1:0]   fold_twelve;
   logic [7:0]            cyc_q;
   logic [16:0]           cyc_base;
   logic                  leap;
   logic [DayWidth-1:0]   len;
   logic [MonthWidth-1:0] cur_month;

   function automatic logic [RawWidth-1:0] mag16(input logic signed [RawWidth-1:0] raw);
      logic [RawWidth-1:0] u;
      u = raw;
      return raw[RawWidth-1] ? (~u + 1'b1) : u;
   endfunction

   assign day_mag   = mag16(day_in);
   assign month_mag = mag16(month_in);
   assign year_mag  = mag16(year_in);

   assign month_m1    = month_ff - 1'b1;
   assign fold_q      = prod_ff[FoldShift +: 13];
   assign fold_twelve = RawWidth'({fold_q, 3'b000}) + RawWidth'({fold_q, 2'b00});
   assign cyc_q       = prod_ff[YearShift +: 8];
   assign cyc_base    = 17'({cyc_q, 8'b0}) + 17'({cyc_q, 7'b0}) + 17'({cyc_q, 4'b0});

   assign cur_month = month_ff[MonthWidth-1:0];
   assign leap = ((rem_ff[1:0] == 2'b00) && (rem_ff != CENTURY_1) && (rem_ff != CENTURY_2)
                  && (rem_ff != CENTURY_3) && (rem_ff != '0)) || (rem_ff == '0);

   always_comb begin
      if (cur_month == MONTH_FEB) begin
         len = leap ? LEN_FEB_LEAP : LEN_FEB;
      end else if ((cur_month == MONTH_APR) || (cur_month == MONTH_JUN) ||
                   (cur_month == MONTH_SEP) || (cur_month == MONTH_NOV)) begin
         len = LEN_SHORT;
      end else begin
         len = LEN_LONG;
      end
   end

   assign status.fits = (day_ff <= RawWidth'(len));

   always_comb begin
      day_in_nxt   = day_ff;
      month_in_nxt = month_ff;
      year_in_nxt  = year_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      if (cmd.load) begin
         day_in_nxt   = (day_mag == '0) ? RawWidth'(1) : day_mag;
         month_in_nxt = (month_mag == '0) ? RawWidth'(1) : month_mag;
         year_in_nxt  = year_mag;
      end
      if (cmd.fold_mul) begin
         prod_in = month_m1 * FOLD_RECIP;
      end
      if (cmd.fold_fix) begin
         month_in_nxt = month_m1 - fold_twelve + 1'b1;
         year_in_nxt  = year_ff + YearWidth'(fold_q);
      end
      if (cmd.year_mul) begin
         prod_in = ProdWidth'(year_ff[YearWidth-1:4]) * ProdWidth'(YEAR_RECIP);
      end
      if (cmd.year_fix) begin
         rem_in = RemWidth'(17'(year_ff) - cyc_base);
      end
      if (cmd.step) begin
         day_in_nxt = day_ff - RawWidth'(len);
         if (cur_month == MONTHS_PER_YEAR) begin
            month_in_nxt = RawWidth'(MONTH_JAN);
            year_in_nxt  = year_ff + 1'b1;
            rem_in       = (rem_ff == LEAP_CYCLE - 1'b1) ? '0 : rem_ff + 1'b1;
         end else begin
            month_in_nxt = month_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in_nxt;
      month_ff <= month_in_nxt;
      year_ff  <= year_in_nxt;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      if (cmd.out_load) begin
         day_out_ff   <= day_ff[DayWidth-1:0];
         month_out_ff <= cur_month;
         year_out_ff  <= year_ff;
      end
   end

   assign day_out   = day_out_ff;
   assign month_out = month_out_ff;
   assign year_out  = year_out_ff;

endmodule

// File: rtl/gdn_controller.sv
module gdn_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  gdn_pkg::gdn_status_type status,
   output gdn_pkg::gdn_cmd_type    cmd
);
   import gdn_pkg::*;

   gdn_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_FOLD_MUL;
            end
         end
         ST_FOLD_MUL: begin
            cmd.fold_mul = 1'b1;
            state_in     = ST_FOLD_FIX;
         end
         ST_FOLD_FIX: begin
            cmd.fold_fix = 1'b1;
            state_in     = ST_YEAR_MUL;
         end
         ST_YEAR_MUL: begin
            cmd.year_mul = 1'b1;
            state_in     = ST_YEAR_FIX;
         end
         ST_YEAR_FIX: begin
            cmd.year_fix = 1'b1;
            state_in     = ST_LOOP;
         end
         ST_LOOP: begin
            if (status.fits) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/gregorian_date_normalizer_unit.sv
// Channel | Dir | Ports                       | tdata fields (low bit up)
// req     | in  | req_tvalid/tready/tdata[47:0] | day_in, month_in, year_in
// rsp     | out | rsp_tvalid/tready/tdata[31:0] | day_out, month_out, year_out, zero pad
//
// An accepted item is loaded, then passes FOLD_MUL, FOLD_FIX, YEAR_MUL, YEAR_FIX,
// LOOP and DONE before rsp_tvalid rises; the next item is taken once it leaves DONE.
// The day loop in LOOP subtracts one month length per cycle until the day fits.
// Reset clears the controller state and rsp_tvalid; datapath holds no control.
// The result sits in an output register, so a new item is taken while it waits;
// a finished item holds in its last state until that register frees.
module gregorian_date_normalizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // day_in[15:0], month_in[31:16], year_in[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // day_out[4:0], month_out[8:5], year_out[24:9], zero
);
   import gdn_pkg::*;

   gdn_cmd_type           cmd;
   gdn_status_type        status;
   logic [DayWidth-1:0]   day_out;
   logic [MonthWidth-1:0] month_out;
   logic [YearWidth-1:0]  year_out;

   gdn_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gdn_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .day_in    (req_tdata[15:0]),
      .month_in  (req_tdata[31:16]),
      .year_in   (req_tdata[47:32]),
      .status    (status),
      .day_out   (day_out),
      .month_out (month_out),
      .year_out  (year_out)
   );

   assign rsp_tdata = {7'b0, year_out, month_out, day_out};

endmodule

// File: rtl/gdn_checker.sv
`include "gregorian_date_normalizer_unit_macros.svh"

module gdn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `GDN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `GDN_ASSERT_NOW(a_day_range, clock, reset, rsp_tvalid, rsp_tdata[4:0] != 5'd0)
   `GDN_ASSERT_NOW(a_month_range, clock, reset, rsp_tvalid, (rsp_tdata[8:5] != 4'd0) && (rsp_tdata[8:5] <= 4'd12))
   `GDN_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:25] == 7'd0)
   `GDN_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind gregorian_date_normalizer_unit gdn_checker u_gdn_checker (.*);

// File: test/gregorian_date_normalizer_unit_test.sv
`timescale 1ns / 1ps

module gregorian_date_normalizer_unit_test;
   import gdn_pkg::*;

   localparam int unsigned RandomDates = 540;
   localparam int unsigned CalmTail    = 50;
   localparam int unsigned DrainCycles = 1200;
   localparam longint unsigned CycleLimit = 4_000_000;

   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
   } date_fields_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // day_in, month_in, year_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // day_out, month_out, year_out, zero pad

   logic [47:0]     raw_dates[$];
   date_fields_type due_dates[$];
   date_fields_type oldest_due;
   int unsigned     dates_total;
   int unsigned     dates_taken;
   int unsigned     error_count;
   int unsigned     req_gap;
   int unsigned     rsp_gap;
   longint unsigned cycle_count;
   bit              req_taken;
   bit              calm;

   gregorian_date_normalizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int unsigned magnitude(input logic [15:0] v);
      return v[15] ? 32'h10000 - int'(v) : int'(v);
   endfunction

   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      if (m == MONTH_FEB) begin
         if ((y % 4 == 0 && y % CENTURY_1 != 0) || y % LEAP_CYCLE == 0) begin
            return LEN_FEB_LEAP;
         end
         return LEN_FEB;
      end
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         return LEN_SHORT;
      end
      return LEN_LONG;
   endfunction

   function automatic date_fields_type normalize_date(input logic [47:0] raw);
      int unsigned     d;
      int unsigned     m;
      int unsigned     y;
      int unsigned     len;
      date_fields_type r;
      d = magnitude(raw[15:0]);
      m = magnitude(raw[31:16]);
      y = magnitude(raw[47:32]);
      if (d == 0) d = 1;
      if (m == 0) m = 1;
      if (m > MONTHS_PER_YEAR) begin
         y += (m - 1) / MONTHS_PER_YEAR;
         m = (m - 1) % MONTHS_PER_YEAR + 1;
      end
      len = month_days(m, y);
      while (d > len) begin
         d -= len;
         m++;
         if (m > MONTHS_PER_YEAR) begin
            m = MONTH_JAN;
            y++;
         end
         len = month_days(m, y);
      end
      r.day   = DayWidth'(d);
      r.month = MonthWidth'(m);
      r.year  = YearWidth'(y);
      return r;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic queue_date(input int d, input int m, input int y);
      raw_dates.push_back({16'(y), 16'(m), 16'(d)});
   endtask

   function automatic logic [15:0] signed_field(input int unsigned top);
      int v;
      v = $urandom_range(0, top);
      if ($urandom_range(0, 1) == 1) v = -v;
      return 16'(v);
   endfunction

   // request driver
   always @(negedge clock) begin
      calm = raw_dates.size() < CalmTail;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (raw_dates.size() > 0) begin
            req_tdata  <= raw_dates.pop_front();
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!reset && !calm && $urandom_range(0, 3) == 0) rsp_gap = $urandom_range(1, 4);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         due_dates.push_back(normalize_date(req_tdata));
         dates_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_dates.size() == 0) begin
            flag_error($sformatf("unexpected transaction tdata=%h", rsp_tdata));
         end else begin
            oldest_due = due_dates.pop_front();
            if (rsp_tdata[DayWidth-1:0] != oldest_due.day)
               flag_error($sformatf("day_out %0d, expected %0d",
                  rsp_tdata[DayWidth-1:0], oldest_due.day));
            if (rsp_tdata[DayWidth +: MonthWidth] != oldest_due.month)
               flag_error($sformatf("month_out %0d, expected %0d",
                  rsp_tdata[DayWidth +: MonthWidth], oldest_due.month));
            if (rsp_tdata[DayWidth+MonthWidth +: YearWidth] != oldest_due.year)
               flag_error($sformatf("year_out %0d, expected %0d",
                  rsp_tdata[DayWidth+MonthWidth +: YearWidth], oldest_due.year));
            if (rsp_tdata[31:DayWidth+MonthWidth+YearWidth] != '0)
               flag_error($sformatf("nonzero pad in tdata=%h", rsp_tdata));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      req_taken   = 1'b0;
      calm        = 1'b0;
      req_gap     = 0;
      rsp_gap     = 0;
      dates_taken = 0;
      error_count = 0;
      cycle_count = 0;

      queue_date(1, 1, 2023);
      queue_date(0, 0, 0);
      queue_date(29, 2, 0);
      queue_date(30, 2, 0);
      queue_date(29, 2, 1900);
      queue_date(29, 2, 2000);
      queue_date(28, 2, 100);
      queue_date(31, 4, 2021);
      queue_date(-32768, -32768, -32768);
      queue_date(32767, 32767, 32767);
      queue_date(-1, -1, -1);
      queue_date(31, 12, -1);
      queue_date(32, 12, 32767);
      queue_date(366, 1, 2024);
      queue_date(365, 1, 2023);
      queue_date(13, 13, 5);
      queue_date(1, 24, 0);
      queue_date(1, 25, 0);
      queue_date(60, 0, 2000);
      queue_date(-31, -12, -2000);
      queue_date(0, -32768, 400);
      queue_date(100, 12, 300);
      queue_date(32767, 0, 32767);

      for (int i = 0; i < RandomDates; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            raw_dates.push_back({16'($urandom), signed_field(12), signed_field(31)});
         end else if (kind < 8) begin
            raw_dates.push_back({16'($urandom), signed_field(40), signed_field(1000)});
         end else begin
            raw_dates.push_back({16'($urandom), 16'($urandom), 16'($urandom)});
         end
      end
      dates_total = raw_dates.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (dates_taken < dates_total) @(posedge clock);
      while (due_dates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
